@@ rtl/sipq_pkg.sv @@
// sipq_pkg: shared types and constants for the sorted insertion priority queue
// used by sipq_ctrl, sipq_datapath and the top level

package sipq_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 16;
    localparam int PAY_W     = 16;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ENQ_CMP,
        S_ENQ_WR,
        S_DEQ_SH,
        S_DEQ_RES
    } t_state;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CAPTURE,
        ACT_ENQ_START,
        ACT_ENQ_STEP,
        ACT_ENQ_PLACE,
        ACT_DEQ_START,
        ACT_DEQ_STEP
    } t_act;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } t_cnt_op;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
    } t_entry;

    typedef struct packed {
        t_act    act;
        logic    res_load;
        t_status res_status;
        logic    res_front;
        t_cnt_op cnt_op;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic count_zero;
        logic full;
        logic later;
        logic idx_one;
        logic last;
    } t_dp_stat;

endpackage

@@ rtl/sorted_insertion_priority_queue.sv @@
// sorted_insertion_priority_queue: one request in flight; clear and refused requests are answered
// from dispatch, enqueue walks the moved entries one entry per cycle over the store's separate
// read and write ports, dequeue shifts every held entry forward and peek reads the front entry
// a new request is taken only after the previous one has loaded its result
// a result left waiting holds the next request in dispatch; synchronous active-low reset
// empties the queue and sets smallest-key-first order; depends on sipq_pkg, sipq_ctrl, sipq_datapath

module sorted_insertion_priority_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_operation,
    input  logic [sipq_pkg::KEY_W-1:0]     i_item_key,
    input  logic [sipq_pkg::PAY_W-1:0]     i_item_payload,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic [sipq_pkg::KEY_W-1:0]     o_out_key,
    output logic [sipq_pkg::PAY_W-1:0]     o_out_payload,
    output logic [sipq_pkg::OUT_CNT_W-1:0] o_entry_count_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_order_select
);
    import sipq_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    sipq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sipq_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_operation        (i_operation),
        .i_item_key         (i_item_key),
        .i_item_payload     (i_item_payload),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_order_select (i_cfg_order_select),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_status           (o_status),
        .o_out_key          (o_out_key),
        .o_out_payload      (o_out_payload),
        .o_entry_count_out  (o_entry_count_out)
    );

endmodule

@@ rtl/sipq_datapath.sv @@
// sipq_datapath: entry store, walk index, count, order register and result registers
// depends on sipq_pkg; driven by commands from sipq_ctrl

module sipq_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_operation,
    input  logic [sipq_pkg::KEY_W-1:0]   i_item_key,
    input  logic [sipq_pkg::PAY_W-1:0]   i_item_payload,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_order_select,
    input  sipq_pkg::t_cmd               i_cmd,
    output sipq_pkg::t_dp_stat           o_stat,
    output logic [1:0]                   o_status,
    output logic [sipq_pkg::KEY_W-1:0]   o_out_key,
    output logic [sipq_pkg::PAY_W-1:0]   o_out_payload,
    output logic [sipq_pkg::OUT_CNT_W-1:0] o_entry_count_out
);
    import sipq_pkg::*;

    t_entry               mem [CAPACITY];
    t_entry               r_rdata;
    t_entry               r_front;
    t_op                  r_op;
    logic [KEY_W-1:0]     r_key;
    logic [PAY_W-1:0]     r_pay;
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_order;
    t_status              r_res_status;
    logic [KEY_W-1:0]     r_res_key;
    logic [PAY_W-1:0]     r_res_pay;
    logic [OUT_CNT_W-1:0] r_res_count;

    logic                 later;
    logic                 last;
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    t_entry               wdata;
    logic [IDX_W-1:0]     raddr;

    // stored entry must go behind the new one
    assign later = r_order ? (r_rdata.key < r_key) : (r_rdata.key > r_key);
    assign last  = ({1'b0, CNT_W'(r_idx)} + 1'b1) >= {1'b0, r_count};

    assign o_stat.op         = r_op;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.full       = (r_count == CNT_W'(CAPACITY));
    assign o_stat.later      = later;
    assign o_stat.idx_one    = (r_idx == IDX_W'(1));
    assign o_stat.last       = last;

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = r_rdata;
        raddr = r_idx;
        case (i_cmd.act)
            ACT_ENQ_START: begin
                raddr = IDX_W'(r_count - 1'b1);
            end
            ACT_ENQ_STEP: begin
                we    = 1'b1;
                wdata = later ? r_rdata : t_entry'({r_key, r_pay});
                raddr = r_idx - IDX_W'(2);
            end
            ACT_ENQ_PLACE: begin
                we    = 1'b1;
                wdata = t_entry'({r_key, r_pay});
            end
            ACT_DEQ_START: begin
                raddr = '0;
            end
            ACT_DEQ_STEP: begin
                we    = (r_idx != '0);
                waddr = r_idx - 1'b1;
                raddr = r_idx + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + 1'b1;
            CNT_DEC: n_count = r_count - 1'b1;
            CNT_CLR: n_count = '0;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_order <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_order <= i_cfg_order_select;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act == ACT_CAPTURE) begin
            r_op  <= t_op'(i_operation);
            r_key <= i_item_key;
            r_pay <= i_item_payload;
        end
        case (i_cmd.act)
            ACT_ENQ_START: r_idx <= r_count[IDX_W-1:0];
            ACT_ENQ_STEP: begin
                if (later) begin
                    r_idx <= r_idx - 1'b1;
                end
            end
            ACT_DEQ_START: r_idx <= '0;
            ACT_DEQ_STEP: begin
                if (r_idx == '0) begin
                    r_front <= r_rdata;
                end
                if (!last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_key    <= i_cmd.res_front ? r_front.key : '0;
            r_res_pay    <= i_cmd.res_front ? r_front.pay : '0;
            r_res_count  <= OUT_CNT_W'(n_count);
        end
    end

    assign o_status          = r_res_status;
    assign o_out_key         = r_res_key;
    assign o_out_payload     = r_res_pay;
    assign o_entry_count_out = r_res_count;

endmodule

@@ rtl/sipq_ctrl.sv @@
// sipq_ctrl: operation sequencer for the priority queue and output valid tracking
// depends on sipq_pkg; commands sipq_datapath

module sipq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  sipq_pkg::t_dp_stat i_stat,
    output sipq_pkg::t_cmd     o_cmd
);
    import sipq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.act        = ACT_NONE;
        o_cmd.res_load   = 1'b0;
        o_cmd.res_status = ST_OK;
        o_cmd.res_front  = 1'b0;
        o_cmd.cnt_op     = CNT_HOLD;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.act = ACT_CAPTURE;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                // wait until the previous result has left the output register
                if (out_free) begin
                    case (i_stat.op)
                        OP_ENQUEUE: begin
                            if (i_stat.full) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_FULL;
                                n_state          = S_IDLE;
                            end else begin
                                o_cmd.act = ACT_ENQ_START;
                                n_state   = i_stat.count_zero ? S_ENQ_WR : S_ENQ_CMP;
                            end
                        end
                        OP_DEQUEUE, OP_PEEK: begin
                            if (i_stat.count_zero) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_EMPTY;
                                n_state          = S_IDLE;
                            end else begin
                                o_cmd.act = ACT_DEQ_START;
                                n_state   = S_DEQ_SH;
                            end
                        end
                        default: begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.cnt_op   = CNT_CLR;
                            n_state        = S_IDLE;
                        end
                    endcase
                end
            end
            S_ENQ_CMP: begin
                o_cmd.act = ACT_ENQ_STEP;
                if (!i_stat.later) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.cnt_op   = CNT_INC;
                    n_state        = S_IDLE;
                end else if (i_stat.idx_one) begin
                    n_state = S_ENQ_WR;
                end
            end
            S_ENQ_WR: begin
                o_cmd.act      = ACT_ENQ_PLACE;
                o_cmd.res_load = 1'b1;
                o_cmd.cnt_op   = CNT_INC;
                n_state        = S_IDLE;
            end
            S_DEQ_SH: begin
                o_cmd.act = ACT_DEQ_STEP;
                if (i_stat.op == OP_PEEK || i_stat.last) begin
                    n_state = S_DEQ_RES;
                end
            end
            S_DEQ_RES: begin
                o_cmd.res_load  = 1'b1;
                o_cmd.res_front = 1'b1;
                o_cmd.cnt_op    = (i_stat.op == OP_DEQUEUE) ? CNT_DEC : CNT_HOLD;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/sipq_checker.sv @@
// sipq_checker: port-level assertions for the priority queue, bound to the top level
// depends on sipq_pkg

module sipq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [1:0]                     o_status,
    input logic [sipq_pkg::KEY_W-1:0]     o_out_key,
    input logic [sipq_pkg::PAY_W-1:0]     o_out_payload,
    input logic [sipq_pkg::OUT_CNT_W-1:0] o_entry_count_out
);
    import sipq_pkg::*;

    localparam logic [OUT_CNT_W-1:0] FULL_CNT = OUT_CNT_W'(CAPACITY);

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |->
            (o_entry_count_out == FULL_CNT && o_out_key == '0 && o_out_payload == '0))
        else $error("full status with wrong count or data");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |->
            (o_entry_count_out == '0 && o_out_key == '0 && o_out_payload == '0))
        else $error("empty status with wrong count or data");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_out_key)
             && $stable(o_entry_count_out)))
        else $error("stalled result changed");

endmodule

bind sorted_insertion_priority_queue sipq_checker u_sipq_checker (.*);

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking bench for sorted_insertion_priority_queue, a directed table then
// random enqueue/dequeue/peek/clear traffic under both serving orders, checked by a predictor
// depends on sipq_pkg and the rtl of the sorted insertion priority queue

module tb_top;

    import sipq_pkg::*;

    localparam int NUM_DIRECTED     = 25;
    localparam int RANDOM_PER_PHASE = 170;
    localparam int HOLD_CYCLES      = 300;
    localparam int CYCLE_LIMIT      = 200000;

    typedef struct packed {
        t_status                status;
        logic [KEY_W-1:0]       key;
        logic [PAY_W-1:0]       pay;
        logic [OUT_CNT_W-1:0]   count;
    } t_pq_result;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        logic             typed;
        t_pq_result       want;
    } t_dir_row;

    localparam t_pq_result NO_WANT   = '{ST_OK, 16'h0000, 16'h0000, 5'd0};
    localparam t_pq_result WANT_EMPTY = '{ST_EMPTY, 16'h0000, 16'h0000, 5'd0};
    localparam t_pq_result WANT_CLEAR = '{ST_OK, 16'h0000, 16'h0000, 5'd0};
    localparam t_pq_result WANT_FULL  = '{ST_FULL, 16'h0000, 16'h0000, 5'd16};

    localparam t_dir_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{OP_PEEK,    16'hFFFF, 16'hFFFF, 1'b1, WANT_EMPTY},
        '{OP_DEQUEUE, 16'h0000, 16'h0000, 1'b1, WANT_EMPTY},
        '{OP_CLEAR,   16'hFFFF, 16'hFFFF, 1'b1, WANT_CLEAR},
        '{OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h8000, 16'hAAAA, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h8000, 16'h5555, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h0001, 16'h1234, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'hFFFE, 16'h8001, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h7FFF, 16'h0FF0, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h8000, 16'hF00F, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h0000, 16'h0001, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h5A5A, 16'hA5A5, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'hFFFF, 16'hFFFE, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h0100, 16'h00FF, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h00FF, 16'hFF00, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h3C3C, 16'hC3C3, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h0002, 16'h7FFF, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h8001, 16'h8000, 1'b0, NO_WANT},
        '{OP_ENQUEUE, 16'h1234, 16'h4321, 1'b1, WANT_FULL},
        '{OP_PEEK,    16'h0F0F, 16'hF0F0, 1'b0, NO_WANT},
        '{OP_DEQUEUE, 16'hFFFF, 16'h0000, 1'b0, NO_WANT},
        '{OP_DEQUEUE, 16'h0000, 16'hFFFF, 1'b0, NO_WANT},
        '{OP_CLEAR,   16'h0000, 16'h0000, 1'b1, WANT_CLEAR},
        '{OP_DEQUEUE, 16'hFFFF, 16'hFFFF, 1'b1, WANT_EMPTY}
    };

    logic                 i_clk              = 1'b0;
    logic                 i_rst_n            = 1'b0;
    logic                 i_in_valid         = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_operation        = OP_CLEAR;
    logic [KEY_W-1:0]     i_item_key         = '0;
    logic [PAY_W-1:0]     i_item_payload     = '0;
    logic                 o_out_valid;
    logic                 i_out_ready        = 1'b0;
    logic [1:0]           o_status;
    logic [KEY_W-1:0]     o_out_key;
    logic [PAY_W-1:0]     o_out_payload;
    logic [OUT_CNT_W-1:0] o_entry_count_out;
    logic                 i_cfg_valid        = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_order_select = 1'b0;

    sorted_insertion_priority_queue dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_item_key         (i_item_key),
        .i_item_payload     (i_item_payload),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_out_key          (o_out_key),
        .o_out_payload      (o_out_payload),
        .o_entry_count_out  (o_entry_count_out),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_order_select (i_cfg_order_select)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the sorted store
    logic [KEY_W-1:0] held_keys [CAPACITY];
    logic [PAY_W-1:0] held_pays [CAPACITY];
    int               held_count = 0;
    logic             largest_first = 1'b0;

    t_pq_result pending_results [$];
    int         errors      = 0;
    int         cycle_count = 0;
    logic       quiet       = 1'b0;
    logic [3:0] hold_token  = '0;
    logic [3:0] hold_seen   = '0;
    int         hold_left   = 0;
    int         idle_left   = 0;

    function automatic t_pq_result queue_apply(t_op op, logic [KEY_W-1:0] key,
                                               logic [PAY_W-1:0] pay);
        t_pq_result r;
        int         i;
        r = NO_WANT;
        case (op)
            OP_ENQUEUE: begin
                if (held_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    i = held_count;
                    while (i > 0 && (largest_first ? (held_keys[i-1] < key)
                                                   : (held_keys[i-1] > key))) begin
                        held_keys[i] = held_keys[i-1];
                        held_pays[i] = held_pays[i-1];
                        i--;
                    end
                    held_keys[i] = key;
                    held_pays[i] = pay;
                    held_count++;
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.key = held_keys[0];
                    r.pay = held_pays[0];
                    if (op == OP_DEQUEUE) begin
                        for (i = 1; i < held_count; i++) begin
                            held_keys[i-1] = held_keys[i];
                            held_pays[i-1] = held_pays[i];
                        end
                        held_count--;
                    end
                end
            end
            default: begin
                held_count = 0;
            end
        endcase
        r.count = OUT_CNT_W'(held_count);
        return r;
    endfunction

    task automatic send_request(input t_op op, input logic [KEY_W-1:0] key,
                                input logic [PAY_W-1:0] pay, input logic typed,
                                input t_pq_result want);
        t_pq_result predicted;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_item_key     <= key;
        i_item_payload <= pay;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        predicted = queue_apply(op, key, pay);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic write_order(input logic desc);
        i_cfg_valid        <= 1'b1;
        i_cfg_order_select <= desc;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        largest_first = desc;
        i_cfg_valid   <= 1'b0;
    endtask

    task automatic wait_results;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key;
        case ($urandom_range(0, 9))
            0:          return 16'h0000;
            1:          return 16'hFFFF;
            2, 3, 4, 5: return KEY_W'($urandom_range(0, 7));
            default:    return KEY_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic check_result;
        t_pq_result exp_r;
        if (pending_results.size() == 0) begin
            $error("result with no request pending: status %0d key %h", o_status, o_out_key);
            errors++;
        end else begin
            exp_r = pending_results.pop_front();
            if (o_status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, o_status);
                errors++;
            end
            if (o_out_key !== exp_r.key) begin
                $error("out_key: expected %h, got %h", exp_r.key, o_out_key);
                errors++;
            end
            if (o_out_payload !== exp_r.pay) begin
                $error("out_payload: expected %h, got %h", exp_r.pay, o_out_payload);
                errors++;
            end
            if (o_entry_count_out !== exp_r.count) begin
                $error("entry_count_out: expected %0d, got %0d", exp_r.count,
                       o_entry_count_out);
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_result();
        if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_left != 0) begin
            idle_left   <= idle_left - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            idle_left   <= $urandom_range(1, 11) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        int         phase;
        int         n;
        int         roll;
        logic       filling;
        t_op        op;
        filling = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_order(1'b0);

        for (n = 0; n < NUM_DIRECTED; n++) begin
            send_request(DIRECTED_ROWS[n].op, DIRECTED_ROWS[n].key, DIRECTED_ROWS[n].pay,
                         DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want);
        end
        i_in_valid <= 1'b0;
        wait_results();

        // order flips between phases while entries are still held
        for (phase = 0; phase < 4; phase++) begin
            write_order(~phase[0]);
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (phase == 3 && n == RANDOM_PER_PHASE - 120) quiet <= 1'b1;
                if (phase == 1 && n == 40) hold_token <= hold_token + 1'b1;
                if (held_count == CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
                if (held_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    op = OP_CLEAR;
                else if (roll < (filling ? 68 : 23))
                    op = OP_ENQUEUE;
                else if (roll < (filling ? 84 : 80))
                    op = OP_DEQUEUE;
                else
                    op = OP_PEEK;
                send_request(op, pick_key(), PAY_W'($urandom_range(0, 65535)),
                             1'b0, NO_WANT);
            end
            i_in_valid <= 1'b0;
            wait_results();
        end

        repeat (CAPACITY + 8) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
